// ----- hdl/indexed_list_insert_erase_defines.svh -----
// Assertion macros used by the checker file of the indexed list block.
// Depends on nothing; the asserting module must have ports i_clk and i_rst_n.
`ifndef INDEXED_LIST_INSERT_ERASE_DEFINES_SVH
`define INDEXED_LIST_INSERT_ERASE_DEFINES_SVH

// A clocked property that is switched off while reset is held.
`define ILIE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// A property that only applies while a result is shown on the output.
`define ILIE_ASSERT_ON_RES(lbl, prop, msg) \
    `ILIE_ASSERT(lbl, o_res_valid |-> (prop), msg)

`endif

// ----- hdl/ilie_pkg.sv -----
// Package for the indexed list block: request and result structs, codes,
// controller states and the command and status groups. Depends on nothing.
package ilie_pkg;

    // Default geometry of the list.
    localparam int DEPTH_DEF     = 64;
    localparam int WORD_BITS_DEF = 32;

    // Operation codes carried in the request.
    typedef enum logic [2:0] {
        MODE_READ   = 3'd0,
        MODE_WRITE  = 3'd1,
        MODE_ERASE  = 3'd2,
        MODE_APPEND = 3'd3,
        MODE_INSERT = 3'd4,
        MODE_RESIZE = 3'd5,
        MODE_CLEAR  = 3'd6
    } t_mode;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_INDEX = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_BEYOND    = 2'd3
    } t_status;

    // One request as it arrives on the input channel.
    typedef struct packed {
        logic [2:0]         mode;
        logic [5:0]         index;
        logic signed [31:0] value;
        logic [6:0]         new_count;
    } t_in_req;

    // One result as it leaves on the output channel.
    typedef struct packed {
        logic signed [31:0] read_value;
        logic [6:0]         element_count;
        logic               is_empty;
        logic [1:0]         status;
    } t_out_res;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ERASE,
        S_INSERT,
        S_PLACE,
        S_FILL,
        S_FIN
    } t_state;

    // Datapath actions, one per cycle.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_READ_IDX,
        OP_WRITE_IDX,
        OP_APPEND,
        OP_CLEAR,
        OP_SET_COUNT,
        OP_DEC,
        OP_ERASE_START,
        OP_ERASE_STEP,
        OP_ERASE_LAST,
        OP_INS_START,
        OP_INS_STEP,
        OP_INS_LAST,
        OP_PLACE,
        OP_FILL_START,
        OP_FILL_STEP,
        OP_FILL_LAST
    } t_dp_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        t_dp_op  op;
        logic    set_status;
        t_status status;
        logic    load_out;
    } t_ctrl_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic [2:0] mode;
        logic       idx_ok;
        logic       full;
        logic       beyond;
        logic       grow;
        logic       erase_first_more;
        logic       erase_more;
        logic       ins_more;
        logic       fill_more;
    } t_dp_stat;

endpackage

// ----- hdl/ilie_ram.sv -----
// Generic single-write, single-read memory with a registered read port.
// Depends on nothing.
module ilie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/ilie_ctrl.sv -----
// Controller of the indexed list: sequences each request through the datapath.
// Depends on ilie_pkg.
module ilie_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    input  ilie_pkg::t_dp_stat i_stat,
    output ilie_pkg::t_ctrl_cmd o_cmd
);

    import ilie_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_res_valid;
    logic   n_res_valid;

    // State and result-valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_cmd       = '{capture: 1'b0, op: OP_NONE, set_status: 1'b0,
                        status: STAT_OK, load_out: 1'b0};

        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end

            S_EXEC: begin
                n_state = S_FIN;
                unique case (i_stat.mode)
                    MODE_READ: begin
                        if (i_stat.idx_ok) begin
                            o_cmd.op = OP_READ_IDX;
                        end else begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = STAT_BAD_INDEX;
                        end
                    end
                    MODE_WRITE: begin
                        if (i_stat.idx_ok) begin
                            o_cmd.op = OP_WRITE_IDX;
                        end else begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = STAT_BAD_INDEX;
                        end
                    end
                    MODE_ERASE: begin
                        if (!i_stat.idx_ok) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = STAT_BAD_INDEX;
                        end else if (i_stat.erase_first_more) begin
                            o_cmd.op = OP_ERASE_START;
                            n_state  = S_ERASE;
                        end else begin
                            // Erasing the last element moves nothing.
                            o_cmd.op = OP_DEC;
                        end
                    end
                    MODE_APPEND: begin
                        if (i_stat.full) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = STAT_FULL;
                        end else begin
                            o_cmd.op = OP_APPEND;
                        end
                    end
                    MODE_INSERT: begin
                        if (!i_stat.idx_ok) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = STAT_BAD_INDEX;
                        end else if (i_stat.full) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = STAT_FULL;
                        end else begin
                            o_cmd.op = OP_INS_START;
                            n_state  = S_INSERT;
                        end
                    end
                    MODE_RESIZE: begin
                        if (i_stat.beyond) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = STAT_BEYOND;
                        end else if (i_stat.grow) begin
                            o_cmd.op = OP_FILL_START;
                            n_state  = S_FILL;
                        end else begin
                            o_cmd.op = OP_SET_COUNT;
                        end
                    end
                    MODE_CLEAR: begin
                        o_cmd.op = OP_CLEAR;
                    end
                    default: begin
                        // The unused code does nothing and reports success.
                        o_cmd.op = OP_NONE;
                    end
                endcase
            end

            // Move entries down by one, from the erased place upward.
            S_ERASE: begin
                if (i_stat.erase_more) begin
                    o_cmd.op = OP_ERASE_STEP;
                end else begin
                    o_cmd.op = OP_ERASE_LAST;
                    n_state  = S_FIN;
                end
            end

            // Move entries up by one, from the top down to the insert place.
            S_INSERT: begin
                if (i_stat.ins_more) begin
                    o_cmd.op = OP_INS_STEP;
                end else begin
                    o_cmd.op = OP_INS_LAST;
                    n_state  = S_PLACE;
                end
            end

            S_PLACE: begin
                o_cmd.op = OP_PLACE;
                n_state  = S_FIN;
            end

            // Zero the new entries of a growing resize.
            S_FILL: begin
                if (i_stat.fill_more) begin
                    o_cmd.op = OP_FILL_STEP;
                end else begin
                    o_cmd.op = OP_FILL_LAST;
                    n_state  = S_FIN;
                end
            end

            // Hand the result over once the output register is free.
            S_FIN: begin
                if (!r_res_valid || i_res_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The output register stays full until its result is taken.
    always_comb begin
        if (o_cmd.load_out) begin
            n_res_valid = 1'b1;
        end else if (i_res_ready) begin
            n_res_valid = 1'b0;
        end else begin
            n_res_valid = r_res_valid;
        end
    end

    assign o_res_valid = r_res_valid;

endmodule

// ----- hdl/ilie_dp.sv -----
// Datapath of the indexed list: request register, count, move pointer,
// element memory and output register. Depends on ilie_pkg and ilie_ram.
module ilie_dp #(
    parameter int DEPTH     = ilie_pkg::DEPTH_DEF,
    parameter int WORD_BITS = ilie_pkg::WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ilie_pkg::t_in_req    i_req,
    input  ilie_pkg::t_ctrl_cmd  i_cmd,
    output ilie_pkg::t_dp_stat   o_stat,
    output ilie_pkg::t_out_res   o_res
);

    import ilie_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    // Compare width: holds the count, the 7-bit target and a carry.
    localparam int XW = ((CW > 7) ? CW : 7) + 1;

    t_in_req          r_req;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [CW-1:0]    r_ptr;
    logic [CW-1:0]    n_ptr;
    t_status          r_status;
    t_status          n_status;
    t_out_res         r_res;

    logic             ram_we;
    logic             ram_re;
    logic [AW-1:0]    ram_waddr;
    logic [AW-1:0]    ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [WORD_BITS-1:0] req_word;
    logic signed [31:0]   rd_ext;

    logic [XW-1:0]    x_count;
    logic [XW-1:0]    x_idx;
    logic [XW-1:0]    x_ptr;
    logic [XW-1:0]    x_tgt;
    logic [XW-1:0]    x_depth;
    logic [XW-1:0]    x_idx_p1;
    logic [XW-1:0]    x_cnt_p1;
    logic [XW-1:0]    x_cnt_m1;
    logic [XW-1:0]    x_ptr_p1;
    logic [XW-1:0]    x_ptr_p2;
    logic [XW-1:0]    x_ptr_m1;
    logic [XW-1:0]    x_ptr_m2;

    // Operands widened to a common compare width.
    assign x_count  = XW'(r_count);
    assign x_idx    = XW'(r_req.index);
    assign x_ptr    = XW'(r_ptr);
    assign x_tgt    = XW'(r_req.new_count);
    assign x_depth  = XW'(DEPTH);
    assign x_idx_p1 = x_idx + XW'(1);
    assign x_cnt_p1 = x_count + XW'(1);
    assign x_cnt_m1 = x_count - XW'(1);
    assign x_ptr_p1 = x_ptr + XW'(1);
    assign x_ptr_p2 = x_ptr + XW'(2);
    assign x_ptr_m1 = x_ptr - XW'(1);
    assign x_ptr_m2 = x_ptr - XW'(2);

    // Request word cut or sign-extended to the stored width, and the stored
    // word sign-extended or cut back to the 32-bit result.
    if (WORD_BITS > 32) begin : g_wide_word
        assign req_word = {{(WORD_BITS - 32){r_req.value[31]}}, r_req.value};
        assign rd_ext   = ram_rdata[31:0];
    end else if (WORD_BITS == 32) begin : g_equal_word
        assign req_word = r_req.value;
        assign rd_ext   = ram_rdata;
    end else begin : g_narrow_word
        assign req_word = r_req.value[WORD_BITS-1:0];
        assign rd_ext   = {{(32 - WORD_BITS){ram_rdata[WORD_BITS-1]}}, ram_rdata};
    end

    // Element store.
    ilie_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Memory accesses, count and pointer updates for each action.
    always_comb begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = r_ptr[AW-1:0];
        ram_raddr = x_idx[AW-1:0];
        ram_wdata = ram_rdata;
        n_count   = r_count;
        n_ptr     = r_ptr;

        unique case (i_cmd.op)
            OP_NONE: begin
                n_count = r_count;
            end
            OP_READ_IDX: begin
                ram_re    = 1'b1;
                ram_raddr = x_idx[AW-1:0];
            end
            OP_WRITE_IDX: begin
                ram_we    = 1'b1;
                ram_waddr = x_idx[AW-1:0];
                ram_wdata = req_word;
            end
            OP_APPEND: begin
                ram_we    = 1'b1;
                ram_waddr = x_count[AW-1:0];
                ram_wdata = req_word;
                n_count   = x_cnt_p1[CW-1:0];
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            OP_SET_COUNT: begin
                n_count = x_tgt[CW-1:0];
            end
            OP_DEC: begin
                n_count = x_cnt_m1[CW-1:0];
            end
            OP_ERASE_START: begin
                ram_re    = 1'b1;
                ram_raddr = x_idx_p1[AW-1:0];
                n_ptr     = x_idx[CW-1:0];
            end
            OP_ERASE_STEP: begin
                ram_we    = 1'b1;
                ram_re    = 1'b1;
                ram_raddr = x_ptr_p2[AW-1:0];
                n_ptr     = x_ptr_p1[CW-1:0];
            end
            OP_ERASE_LAST: begin
                ram_we  = 1'b1;
                n_count = x_cnt_m1[CW-1:0];
            end
            OP_INS_START: begin
                ram_re    = 1'b1;
                ram_raddr = x_cnt_m1[AW-1:0];
                n_ptr     = r_count;
            end
            OP_INS_STEP: begin
                ram_we    = 1'b1;
                ram_re    = 1'b1;
                ram_raddr = x_ptr_m2[AW-1:0];
                n_ptr     = x_ptr_m1[CW-1:0];
            end
            OP_INS_LAST: begin
                ram_we = 1'b1;
            end
            OP_PLACE: begin
                ram_we    = 1'b1;
                ram_waddr = x_idx[AW-1:0];
                ram_wdata = req_word;
                n_count   = x_cnt_p1[CW-1:0];
            end
            OP_FILL_START: begin
                n_ptr = r_count;
            end
            OP_FILL_STEP: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                n_ptr     = x_ptr_p1[CW-1:0];
            end
            OP_FILL_LAST: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                n_count   = x_tgt[CW-1:0];
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Status is cleared with each new request and set once if it is refused.
    always_comb begin
        n_status = r_status;
        if (i_cmd.capture) begin
            n_status = STAT_OK;
        end else if (i_cmd.set_status) begin
            n_status = i_cmd.status;
        end
    end

    // The element count is the only datapath register with a reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Request, pointer and status registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        r_ptr    <= n_ptr;
        r_status <= n_status;
    end

    // Output register, loaded when the controller hands over a result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_res.read_value    <= (r_req.mode == MODE_READ && r_status == STAT_OK)
                                   ? rd_ext : '0;
            r_res.element_count <= x_count[6:0];
            r_res.is_empty      <= (r_count == '0);
            r_res.status        <= r_status;
        end
    end

    assign o_res = r_res;

    // Checks the controller decides on.
    assign o_stat.mode             = r_req.mode;
    assign o_stat.idx_ok           = (x_idx < x_count);
    assign o_stat.full             = (x_count >= x_depth);
    assign o_stat.beyond           = (x_tgt > x_depth);
    assign o_stat.grow             = (x_count < x_tgt);
    assign o_stat.erase_first_more = (x_idx_p1 < x_count);
    assign o_stat.erase_more       = (x_ptr_p2 < x_count);
    assign o_stat.ins_more         = (x_ptr_m1 > x_idx);
    assign o_stat.fill_more        = (x_ptr_p1 < x_tgt);

endmodule

// ----- hdl/indexed_list_insert_erase.sv -----
// Indexed list of signed words with read, write, erase, append, insert,
// resize and clear requests; one result per request. Each request goes through
// an accept state, an execute state and a state that hands over the result.
// Erase, insert and a growing resize add states in between: moves and fills
// go through the element memory one entry per cycle, and insert then places
// the new word. A new request is taken once the previous one has been handed
// to the output register, even while that result still waits to be taken.
// The element memory needs no clearing after reset.
module indexed_list_insert_erase #(
    parameter int DEPTH     = ilie_pkg::DEPTH_DEF,
    parameter int WORD_BITS = ilie_pkg::WORD_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  ilie_pkg::t_in_req  i_req,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output ilie_pkg::t_out_res o_res
);

    import ilie_pkg::*;

    t_ctrl_cmd cmd;
    t_dp_stat  stat;

    // Sequencer.
    ilie_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Storage and arithmetic.
    ilie_dp #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_res   (o_res)
    );

endmodule

// ----- hdl/ilie_checker.sv -----
// Port-level checks for the indexed list, bound to the top level.
// Depends on ilie_pkg and the assertion macro header.
`include "indexed_list_insert_erase_defines.svh"

module ilie_checker #(
    parameter int DEPTH = ilie_pkg::DEPTH_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_req_valid,
    input logic               o_req_ready,
    input logic               o_res_valid,
    input logic               i_res_ready,
    input ilie_pkg::t_out_res o_res
);

    import ilie_pkg::*;

    // A stalled result holds still.
    `ILIE_ASSERT(a_res_hold, o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_res), "result changed while stalled")

    // The block works on one request at a time.
    `ILIE_ASSERT(a_one_at_a_time, i_req_valid && o_req_ready |=> !o_req_ready, "ready right after a request")

    // The empty flag follows the count.
    `ILIE_ASSERT_ON_RES(a_empty_flag, o_res.is_empty == (o_res.element_count == 7'd0), "empty flag wrong")

    // A refused request never returns data.
    `ILIE_ASSERT_ON_RES(a_refused_zero, o_res.status == STAT_OK || o_res.read_value == 32'sd0, "data on refused request")

    // The count never passes the capacity.
    `ILIE_ASSERT_ON_RES(a_count_cap, 32'(o_res.element_count) <= DEPTH, "count above capacity")

endmodule

bind indexed_list_insert_erase ilie_checker #(.DEPTH(DEPTH)) u_checker (.*);

// ----- test/list_scoreboard_pkg.sv -----
// Scoreboard for the indexed list testbench: a bit-accurate list predictor
// and the queue of results it expects. Depends on ilie_pkg for the payload types.
`timescale 1ns / 100ps

package list_scoreboard_pkg;

    import ilie_pkg::*;

    localparam int LIST_DEPTH = 64;

    class list_scoreboard;

        logic [31:0] words [LIST_DEPTH];
        int          list_count;
        t_out_res    expected_results [$];
        int          error_count;

        function new();
            list_count  = 0;
            error_count = 0;
            foreach (words[i]) words[i] = '0;
        endfunction

        // Apply one accepted request to the predicted list and queue its result.
        function void note_request(t_in_req req);
            t_out_res res;
            int       idx;
            int       target;
            int       k;
            res    = '0;
            idx    = int'(req.index);
            target = int'(req.new_count);
            res.status = STAT_OK;
            case (req.mode)
                MODE_READ: begin
                    if (idx < list_count) res.read_value = words[idx];
                    else res.status = STAT_BAD_INDEX;
                end
                MODE_WRITE: begin
                    if (idx < list_count) words[idx] = req.value;
                    else res.status = STAT_BAD_INDEX;
                end
                MODE_ERASE: begin
                    if (idx < list_count) begin
                        for (k = idx; k + 1 < list_count; k++) words[k] = words[k + 1];
                        list_count--;
                    end else begin
                        res.status = STAT_BAD_INDEX;
                    end
                end
                MODE_APPEND: begin
                    if (list_count >= LIST_DEPTH) begin
                        res.status = STAT_FULL;
                    end else begin
                        words[list_count] = req.value;
                        list_count++;
                    end
                end
                MODE_INSERT: begin
                    // Index checked first: insert at the count is a bad index.
                    if (idx >= list_count) begin
                        res.status = STAT_BAD_INDEX;
                    end else if (list_count >= LIST_DEPTH) begin
                        res.status = STAT_FULL;
                    end else begin
                        for (k = list_count; k > idx; k--) words[k] = words[k - 1];
                        words[idx] = req.value;
                        list_count++;
                    end
                end
                MODE_RESIZE: begin
                    if (target > LIST_DEPTH) begin
                        res.status = STAT_BEYOND;
                    end else begin
                        // Growth zero-fills; a shrink only cuts the count.
                        for (k = list_count; k < target; k++) words[k] = '0;
                        list_count = target;
                    end
                end
                MODE_CLEAR: begin
                    list_count = 0;
                end
                default: begin
                end
            endcase
            res.element_count = 7'(list_count);
            res.is_empty      = (list_count == 0);
            expected_results.push_back(res);
        endfunction

        // Compare one accepted result with the oldest expected one.
        function void check_result(t_out_res got);
            t_out_res want;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h with no request pending", $time, got);
                error_count++;
                return;
            end
            want = expected_results.pop_front();
            if (got.read_value !== want.read_value) begin
                $display("%0t: read_value expected %h actual %h",
                         $time, want.read_value, got.read_value);
                error_count++;
            end
            if (got.element_count !== want.element_count) begin
                $display("%0t: element_count expected %0d actual %0d",
                         $time, want.element_count, got.element_count);
                error_count++;
            end
            if (got.is_empty !== want.is_empty) begin
                $display("%0t: is_empty expected %b actual %b",
                         $time, want.is_empty, got.is_empty);
                error_count++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, got.status);
                error_count++;
            end
        endfunction

    endclass

endpackage

// ----- test/tb_top.sv -----
// Top-level testbench for indexed_list_insert_erase: directed and random
// requests with bursty input and stalling output. Depends on ilie_pkg and list_scoreboard_pkg.
`timescale 1ns / 100ps

module tb_top;

    import ilie_pkg::*;
    import list_scoreboard_pkg::*;

    localparam logic [2:0] MODE_UNUSED    = 3'd7;
    localparam int         RANDOM_ITEMS   = 1600;
    localparam int         PHASE_ITEMS    = 150;
    localparam int         TAIL_CYCLES    = 80;
    localparam int         WATCHDOG_LIMIT = 4000;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_SPARSE,
        RDY_PATTERN
    } t_ready_style;

    logic         i_clk       = 1'b0;
    logic         i_rst_n     = 1'b0;
    logic         req_valid   = 1'b0;
    logic         res_ready   = 1'b0;
    t_in_req      req_payload = '0;
    logic         o_req_ready;
    logic         o_res_valid;
    t_out_res     o_res;

    list_scoreboard sb;
    int           burst_left  = 0;
    int           idle_cycles = 0;
    int           stall_left  = 0;
    t_ready_style ready_style = RDY_ALWAYS;
    logic [7:0]   pattern_cnt = '0;

    indexed_list_insert_erase DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (req_payload),
        .o_res_valid (o_res_valid),
        .i_res_ready (res_ready),
        .o_res       (o_res)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_in_req make_request(logic [2:0] mode, int index,
                                             logic [31:0] value, int new_count);
        t_in_req req;
        req.mode      = mode;
        req.index     = 6'(index);
        req.value     = value;
        req.new_count = 7'(new_count);
        return req;
    endfunction

    // Random request; the mode mix leans toward growth or shrink by phase.
    function automatic t_in_req random_request(int count, bit grow_phase);
        t_in_req     req;
        int          pick;
        logic [2:0]  mode;
        int          index;
        logic [31:0] value;
        int          new_count;
        pick = $urandom_range(0, 99);
        if (grow_phase) begin
            if      (pick < 12) mode = MODE_READ;
            else if (pick < 24) mode = MODE_WRITE;
            else if (pick < 34) mode = MODE_ERASE;
            else if (pick < 64) mode = MODE_APPEND;
            else if (pick < 89) mode = MODE_INSERT;
            else if (pick < 96) mode = MODE_RESIZE;
            else if (pick < 97) mode = MODE_CLEAR;
            else if (pick < 98) mode = MODE_UNUSED;
            else                mode = MODE_READ;
        end else begin
            if      (pick < 15) mode = MODE_READ;
            else if (pick < 30) mode = MODE_WRITE;
            else if (pick < 65) mode = MODE_ERASE;
            else if (pick < 73) mode = MODE_APPEND;
            else if (pick < 81) mode = MODE_INSERT;
            else if (pick < 95) mode = MODE_RESIZE;
            else if (pick < 97) mode = MODE_CLEAR;
            else                mode = MODE_UNUSED;
        end
        // Mostly live positions, sometimes the count itself or anywhere.
        if (count > 0 && $urandom_range(0, 7) != 0) index = $urandom_range(0, count - 1);
        else if (count < LIST_DEPTH && $urandom_range(0, 3) == 0) index = count;
        else index = $urandom_range(0, 63);
        case ($urandom_range(0, 7))
            0:       value = 32'h7fff_ffff;
            1:       value = 32'h8000_0000;
            2:       value = 32'h0000_0000;
            3:       value = 32'hffff_ffff;
            default: value = $urandom;
        endcase
        if ($urandom_range(0, 6) != 0) new_count = $urandom_range(0, 64);
        else new_count = $urandom_range(65, 127);
        req = make_request(mode, index, value, new_count);
        return req;
    endfunction

    // Present one request, wait for the handshake, then keep bursting or pause.
    task automatic send_request(input t_in_req req);
        req_payload <= req;
        req_valid   <= 1'b1;
        do @(posedge i_clk); while (!o_req_ready);
        sb.note_request(req);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            req_valid <= 1'b0;
            repeat ($urandom_range(0, 5) == 0 ? $urandom_range(10, 30)
                                              : $urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 10);
        end
    endtask

    // Result checking, watchdog counter and the receiver's stall pattern.
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && res_ready) sb.check_result(o_res);
        if (i_rst_n && ((req_valid && o_req_ready) || (o_res_valid && res_ready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (stall_left == 0) begin
            ready_style <= t_ready_style'($urandom_range(0, 3));
            stall_left  <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (ready_style)
            RDY_ALWAYS:  res_ready <= 1'b1;
            RDY_COIN:    res_ready <= 1'($urandom_range(0, 1));
            RDY_SPARSE:  res_ready <= ($urandom_range(0, 3) == 0);
            RDY_PATTERN: res_ready <= (pattern_cnt[2:0] < 3'd5);
            default:     res_ready <= 1'b1;
        endcase
        pattern_cnt <= pattern_cnt + 1'b1;
    end

    // Watchdog: stop when nothing has been accepted for too long.
    initial begin
        do @(posedge i_clk); while (idle_cycles < WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // Main sequence: reset, directed requests, random requests, drain.
    initial begin
        int n;
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-list refusals, extremes, insert at the count,
        // full list, resize beyond capacity, shrink then regrow, unused mode.
        send_request(make_request(MODE_READ,   0,  32'h0,         0));
        send_request(make_request(MODE_INSERT, 0,  32'h1234_5678, 0));
        send_request(make_request(MODE_ERASE,  0,  32'h0,         0));
        send_request(make_request(MODE_APPEND, 0,  32'h7fff_ffff, 0));
        send_request(make_request(MODE_APPEND, 63, 32'h8000_0000, 0));
        send_request(make_request(MODE_INSERT, 0,  32'hffff_ffff, 0));
        send_request(make_request(MODE_INSERT, 1,  32'h0000_0000, 0));
        send_request(make_request(MODE_INSERT, 4,  32'hdead_beef, 0));
        send_request(make_request(MODE_READ,   3,  32'h0,         0));
        send_request(make_request(MODE_WRITE,  2,  32'h5555_aaaa, 0));
        send_request(make_request(MODE_WRITE,  4,  32'haaaa_5555, 0));
        send_request(make_request(MODE_ERASE,  0,  32'h0,         0));
        send_request(make_request(MODE_RESIZE, 0,  32'h0,         64));
        send_request(make_request(MODE_APPEND, 0,  32'h0bad_f00d, 0));
        send_request(make_request(MODE_INSERT, 63, 32'h0bad_f00d, 0));
        send_request(make_request(MODE_READ,   63, 32'h0,         0));
        send_request(make_request(MODE_WRITE,  63, 32'hc001_d00d, 0));
        send_request(make_request(MODE_ERASE,  63, 32'h0,         0));
        send_request(make_request(MODE_INSERT, 62, 32'h8000_0001, 0));
        send_request(make_request(MODE_RESIZE, 0,  32'h0,         127));
        send_request(make_request(MODE_RESIZE, 0,  32'h0,         65));
        send_request(make_request(MODE_RESIZE, 0,  32'h0,         2));
        send_request(make_request(MODE_RESIZE, 0,  32'h0,         6));
        send_request(make_request(MODE_UNUSED, 5,  32'hffff_ffff, 127));
        send_request(make_request(MODE_CLEAR,  0,  32'h0,         0));
        send_request(make_request(MODE_READ,   0,  32'h0,         0));

        // Random requests in alternating growth and shrink phases.
        for (n = 0; n < RANDOM_ITEMS; n++)
            send_request(random_request(sb.list_count, ((n / PHASE_ITEMS) % 2) == 0));
        req_valid <= 1'b0;

        // Drain outstanding results, then give stray results time to show up.
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/ilie_pkg.sv
hdl/ilie_ram.sv
hdl/ilie_ctrl.sv
hdl/ilie_dp.sv
hdl/indexed_list_insert_erase.sv
hdl/ilie_checker.sv
test/list_scoreboard_pkg.sv
test/tb_top.sv
